// ===== rtl/affine_forward_pixel_mapper_core_macros.svh =====
// Assertion macros shared by the affine forward pixel mapper RTL.
`ifndef AFFINE_FORWARD_PIXEL_MAPPER_CORE_MACROS_SVH
`define AFFINE_FORWARD_PIXEL_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afpm: same-cycle check failed");

// Implication with a fixed delay in cycles, disabled while reset is asserted.
`define AFPM_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("afpm: delayed check failed");

`endif

// ===== rtl/afpm_pkg.sv =====
// Package with the types and constants of the affine forward pixel mapper.
package afpm_pkg;

  localparam int COORD_W   = 11;
  localparam int DIM_W     = 12;
  localparam int INDEX_W   = 22;
  localparam int COLOR_W   = 32;
  localparam int FIX_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM   = 2048;
  localparam int CFG_IDX_W = 3;

  // Unsigned coordinate times signed step, then the sum of three terms.
  localparam int PROD_W = COORD_W + 1 + FIX_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W + 1;
  localparam int MAG_W  = RND_W - FRAC_BITS;
  localparam int PIX_W  = COORD_W + DIM_W;

  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_COL_STEP_X   = 3'd2,
    REG_COL_STEP_Y   = 3'd3,
    REG_ROW_STEP_X   = 3'd4,
    REG_ROW_STEP_Y   = 3'd5,
    REG_SCREEN_W     = 3'd6,
    REG_SCREEN_H     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [FIX_W-1:0] origin_x;
    logic signed [FIX_W-1:0] origin_y;
    logic signed [FIX_W-1:0] col_step_x;
    logic signed [FIX_W-1:0] col_step_y;
    logic signed [FIX_W-1:0] row_step_x;
    logic signed [FIX_W-1:0] row_step_y;
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_cx;
    logic signed [PROD_W-1:0] prod_cy;
    logic signed [PROD_W-1:0] prod_rx;
    logic signed [PROD_W-1:0] prod_ry;
    logic [COLOR_W-1:0]       color;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/afpm_cfg.sv =====
// Configuration register file of the affine forward pixel mapper.
module afpm_cfg
  import afpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FIX_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  logic signed [FIX_W-1:0] origin_x_q, origin_y_q;
  logic signed [FIX_W-1:0] col_step_x_q, col_step_y_q;
  logic signed [FIX_W-1:0] row_step_x_q, row_step_y_q;
  logic [DIM_W-1:0]        screen_w_q, screen_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      col_step_x_q <= FIX_W'(65536);
      col_step_y_q <= '0;
      row_step_x_q <= '0;
      row_step_y_q <= FIX_W'(65536);
      screen_w_q   <= DIM_W'(640);
      screen_h_q   <= DIM_W'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        REG_COL_STEP_X: col_step_x_q <= cfg_data_i;
        REG_COL_STEP_Y: col_step_y_q <= cfg_data_i;
        REG_ROW_STEP_X: row_step_x_q <= cfg_data_i;
        REG_ROW_STEP_Y: row_step_y_q <= cfg_data_i;
        REG_SCREEN_W:   screen_w_q   <= cfg_data_i[DIM_W-1:0];
        REG_SCREEN_H:   screen_h_q   <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.origin_x   = origin_x_q;
    cfg_o.origin_y   = origin_y_q;
    cfg_o.col_step_x = col_step_x_q;
    cfg_o.col_step_y = col_step_y_q;
    cfg_o.row_step_x = row_step_x_q;
    cfg_o.row_step_y = row_step_y_q;
    // Sizes above the largest supported frame saturate.
    cfg_o.width  = (screen_w_q > MAX_DIM_V) ? MAX_DIM_V : screen_w_q;
    cfg_o.height = (screen_h_q > MAX_DIM_V) ? MAX_DIM_V : screen_h_q;
  end

endmodule

// ===== rtl/afpm_front.sv =====
// Front end: takes pixel requests and forms the four step products.
module afpm_front
  import afpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] src_x_i,
  input  logic [COORD_W-1:0] src_y_i,
  input  logic [COLOR_W-1:0] pixel_color_i,
  input  cfg_t               cfg_i,
  input  qstat_t             qstat_i,
  output logic               push_o,
  output item_t              item_o
);

  logic  valid_q;
  item_t item_q;
  item_t item_d;
  logic  accept;
  logic signed [COORD_W:0] sx_s, sy_s;

  assign busy   = valid_q && qstat_i.full;
  assign accept = start && !busy;
  assign push_o = valid_q && !qstat_i.full;
  assign item_o = item_q;

  assign sx_s = $signed({1'b0, src_x_i});
  assign sy_s = $signed({1'b0, src_y_i});

  always_comb begin
    item_d.prod_cx = PROD_W'(sx_s) * PROD_W'(cfg_i.col_step_x);
    item_d.prod_cy = PROD_W'(sx_s) * PROD_W'(cfg_i.col_step_y);
    item_d.prod_rx = PROD_W'(sy_s) * PROD_W'(cfg_i.row_step_x);
    item_d.prod_ry = PROD_W'(sy_s) * PROD_W'(cfg_i.row_step_y);
    item_d.color   = pixel_color_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/afpm_queue.sv =====
// Short FIFO that decouples the front end from the back end.
module afpm_queue
  import afpm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t qstat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign qstat_o.full  = (count_q == CNT_W'(DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign item_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/afpm_back.sv =====
// Back end: sums, rounds, bounds-checks and indexes each mapped pixel.
module afpm_back
  import afpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  qstat_t             qstat_i,
  input  item_t              item_i,
  output logic               pop_o,
  output logic               result_valid_o,
  output logic               in_range_o,
  output logic [COORD_W-1:0] dest_x_o,
  output logic [COORD_W-1:0] dest_y_o,
  output logic [INDEX_W-1:0] dest_index_o,
  output logic [COLOR_W-1:0] out_color_o
);

  // Stage 1: destination point in fixed point.
  logic                    v1_q;
  logic signed [SUM_W-1:0] px_q, py_q;
  logic [COLOR_W-1:0]      color1_q;

  // Stage 2: rounded and checked coordinates.
  logic               v2_q;
  logic               ok2_q;
  logic [COORD_W-1:0] rx2_q, ry2_q;
  logic [COLOR_W-1:0] color2_q;

  logic [MAG_W-1:0] mag_x, mag_y;
  logic             ok_x, ok_y, ok;
  logic [PIX_W-1:0] row_base;

  assign pop_o = !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      v1_q           <= pop_o;
      v2_q           <= v1_q;
      result_valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      px_q <= SUM_W'(cfg_i.origin_x) + SUM_W'(item_i.prod_cx) + SUM_W'(item_i.prod_rx);
      py_q <= SUM_W'(cfg_i.origin_y) + SUM_W'(item_i.prod_cy) + SUM_W'(item_i.prod_ry);
      color1_q <= item_i.color;
    end
  end

  // Round half away from zero: positive values add a half, others take the
  // magnitude plus a half, then both drop the fraction.
  function automatic logic [MAG_W-1:0] round_mag(input logic signed [SUM_W-1:0] v);
    logic signed [RND_W-1:0] up_pos;
    logic signed [RND_W-1:0] up_neg;
    logic                    pos;
    pos    = !v[SUM_W-1] && (v != '0);
    up_pos = RND_W'(v) + HALF;
    up_neg = HALF - RND_W'(v);
    return pos ? up_pos[RND_W-1:FRAC_BITS] : up_neg[RND_W-1:FRAC_BITS];
  endfunction

  // A coordinate is usable if it rounds to zero or comes from a positive
  // value, and stays below the frame size.
  function automatic logic coord_ok(input logic signed [SUM_W-1:0] v,
                                    input logic [MAG_W-1:0] m,
                                    input logic [DIM_W-1:0] lim);
    logic pos;
    pos = !v[SUM_W-1] && (v != '0);
    return (pos || (m == '0)) && (m < MAG_W'(lim));
  endfunction

  always_comb begin
    mag_x = round_mag(px_q);
    mag_y = round_mag(py_q);
    ok_x  = coord_ok(px_q, mag_x, cfg_i.width);
    ok_y  = coord_ok(py_q, mag_y, cfg_i.height);
    ok    = ok_x && ok_y;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      ok2_q    <= ok;
      rx2_q    <= ok ? mag_x[COORD_W-1:0] : '0;
      ry2_q    <= ok ? mag_y[COORD_W-1:0] : '0;
      color2_q <= color1_q;
    end
  end

  assign row_base = PIX_W'(ry2_q) * PIX_W'(cfg_i.width);

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      in_range_o   <= ok2_q;
      dest_x_o     <= rx2_q;
      dest_y_o     <= ry2_q;
      dest_index_o <= INDEX_W'(row_base + PIX_W'(rx2_q));
      out_color_o  <= color2_q;
    end
  end

endmodule

// ===== rtl/affine_forward_pixel_mapper_core.sv =====
// Top level of the affine forward pixel mapper: config, front end, queue, back end.
// A request taken at an edge passes the front-end register, the queue, the sum stage,
// the rounding stage and the output register. Throughput: one pixel per clock.
// The receiver cannot stall, so the queue never fills and busy stays low in use.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and queue and loads
// the register defaults: identity steps, origin zero, a 640 by 480 screen.
`include "affine_forward_pixel_mapper_core_macros.svh"

module affine_forward_pixel_mapper_core
  import afpm_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Pixel requests.
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   src_x_i,
  input  logic [COORD_W-1:0]   src_y_i,
  input  logic [COLOR_W-1:0]   pixel_color_i,

  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FIX_W-1:0]     cfg_data_i,

  // Mapped results, one strobe per request.
  output logic                 result_valid_o,
  output logic                 in_range_o,
  output logic [COORD_W-1:0]   dest_x_o,
  output logic [COORD_W-1:0]   dest_y_o,
  output logic [INDEX_W-1:0]   dest_index_o,
  output logic [COLOR_W-1:0]   out_color_o
);

  cfg_t   cfg;
  qstat_t qstat;
  item_t  front_item;
  item_t  head_item;
  logic   push;
  logic   pop;

  // The register file clamps the screen size so downstream logic only sees
  // sizes that fit the coordinate range.
  afpm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The front end registers the four coordinate-by-step products of each
  // accepted request, so the multipliers sit right behind the input ports.
  afpm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .pixel_color_i (pixel_color_i),
    .cfg_i         (cfg),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (front_item)
  );

  // The queue lets the front end keep taking requests even if the back end
  // were to pause; with a receiver that never stalls it holds at most one item.
  afpm_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .qstat_o (qstat)
  );

  // The back end runs three stages: the wide three-term sums, the rounding
  // and bounds check, and the row times width index with the output register.
  afpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .qstat_i        (qstat),
    .item_i         (head_item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .in_range_o     (in_range_o),
    .dest_x_o       (dest_x_o),
    .dest_y_o       (dest_y_o),
    .dest_index_o   (dest_index_o),
    .out_color_o    (out_color_o)
  );

  // Every accepted request produces its result after the front end, queue and back-end stages.
  `AFPM_ASSERT_DLY(a_fixed_latency, clk_i, rst_ni, start && !busy, 5, result_valid_o)
  // The back end drains one item per cycle, so the front end never backs up.
  `AFPM_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy)
  // A pixel reported in range lies inside the (clamped) screen.
  `AFPM_ASSERT_IMP(a_inside_screen, clk_i, rst_ni, result_valid_o && in_range_o,
                   (DIM_W'(dest_x_o) < cfg.width) && (DIM_W'(dest_y_o) < cfg.height))
  // A pixel off the screen carries zero coordinates and index.
  `AFPM_ASSERT_IMP(a_off_screen_zero, clk_i, rst_ni, result_valid_o && !in_range_o,
                   (dest_x_o == '0) && (dest_y_o == '0) && (dest_index_o == '0))

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the affine forward pixel mapper core.
module tb_top
  import afpm_pkg::*;
;

  // Watchdog limit for the whole run, with a wide margin over a correct run.
  localparam int CYCLE_LIMIT  = 150000;
  // Extra wait after the last outstanding result before the settings change.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 13;
  localparam int PIXELS_PER_PHASE = 87;

  typedef struct packed {
    logic                 in_range;
    logic [COORD_W-1:0]   dest_x;
    logic [COORD_W-1:0]   dest_y;
    logic [INDEX_W-1:0]   dest_index;
    logic [COLOR_W-1:0]   color;
  } mapped_px_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
  } pixel_req_t;

  // Holds a private copy of the mapping registers, predicts where each accepted
  // pixel lands, and compares the strobed results against those predictions in order.
  class pixel_map_scoreboard;
    cfg_t       regs;
    mapped_px_t expected_q[$];
    int         mismatches;
    int         results_seen;
    int         inside_seen;

    function new();
      regs.origin_x   = '0;
      regs.origin_y   = '0;
      regs.col_step_x = 32'sh0001_0000;
      regs.col_step_y = '0;
      regs.row_step_x = '0;
      regs.row_step_y = 32'sh0001_0000;
      regs.width      = DIM_W'(640);
      regs.height     = DIM_W'(480);
      mismatches   = 0;
      results_seen = 0;
      inside_seen  = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [FIX_W-1:0] data);
      case (idx)
        REG_ORIGIN_X:   regs.origin_x   = data;
        REG_ORIGIN_Y:   regs.origin_y   = data;
        REG_COL_STEP_X: regs.col_step_x = data;
        REG_COL_STEP_Y: regs.col_step_y = data;
        REG_ROW_STEP_X: regs.row_step_x = data;
        REG_ROW_STEP_Y: regs.row_step_y = data;
        REG_SCREEN_W:   regs.width      = data[DIM_W-1:0];
        REG_SCREEN_H:   regs.height     = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Half away from zero: magnitude plus one half, then drop the fraction.
    function longint round_to_pixel(longint v);
      longint half;
      half = longint'(1) <<< (FRAC_BITS - 1);
      if (v > 0) return (v + half) >>> FRAC_BITS;
      return -((-v + half) >>> FRAC_BITS);
    endfunction

    function mapped_px_t map_pixel(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                   logic [COLOR_W-1:0] color);
      longint     px, py, rx, ry, w, h;
      mapped_px_t m;
      w = (regs.width  > MAX_DIM_V) ? longint'(MAX_DIM) : longint'(regs.width);
      h = (regs.height > MAX_DIM_V) ? longint'(MAX_DIM) : longint'(regs.height);
      px = longint'($signed(regs.origin_x)) + longint'(sx) * longint'($signed(regs.col_step_x))
         + longint'(sy) * longint'($signed(regs.row_step_x));
      py = longint'($signed(regs.origin_y)) + longint'(sx) * longint'($signed(regs.col_step_y))
         + longint'(sy) * longint'($signed(regs.row_step_y));
      rx = round_to_pixel(px);
      ry = round_to_pixel(py);
      m = '0;
      m.color = color;
      if (rx >= 0 && ry >= 0 && rx < w && ry < h) begin
        m.in_range   = 1'b1;
        m.dest_x     = rx[COORD_W-1:0];
        m.dest_y     = ry[COORD_W-1:0];
        m.dest_index = INDEX_W'(ry * w + rx);
      end
      return m;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                             logic [COLOR_W-1:0] color);
      expected_q.push_back(map_pixel(sx, sy, color));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] map error: %s", $time, msg);
    endtask

    task check_result(logic in_range, logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy,
                      logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
      mapped_px_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (want.in_range) inside_seen++;
      if (in_range !== want.in_range)
        report_mismatch($sformatf("in_range %b, expected %b", in_range, want.in_range));
      if (dx !== want.dest_x)
        report_mismatch($sformatf("dest_x %0d, expected %0d", dx, want.dest_x));
      if (dy !== want.dest_y)
        report_mismatch($sformatf("dest_y %0d, expected %0d", dy, want.dest_y));
      if (idx !== want.dest_index)
        report_mismatch($sformatf("dest_index %0d, expected %0d", idx, want.dest_index));
      if (color !== want.color)
        report_mismatch($sformatf("out_color %h, expected %h", color, want.color));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [COORD_W-1:0]   src_x_i;
  logic [COORD_W-1:0]   src_y_i;
  logic [COLOR_W-1:0]   pixel_color_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [FIX_W-1:0]     cfg_data_i;
  logic                 result_valid_o;
  logic                 in_range_o;
  logic [COORD_W-1:0]   dest_x_o;
  logic [COORD_W-1:0]   dest_y_o;
  logic [INDEX_W-1:0]   dest_index_o;
  logic [COLOR_W-1:0]   out_color_o;

  pixel_map_scoreboard sb;
  pixel_req_t          pixel_q[$];
  int                  cycles;
  int                  requests_taken;
  int                  settings_loaded;

  affine_forward_pixel_mapper_core dut (.*);

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles, sb.pending());
      $display("affine_forward_pixel_mapper_core: mismatch");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, before the driver's
  // nonblocking updates land, so the values seen are those the block saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        sb.check_result(in_range_o, dest_x_o, dest_y_o, dest_index_o, out_color_o);
      if (start && !busy)
        sb.note_pixel(src_x_i, src_y_i, pixel_color_i);
    end
  end

  // Writes all eight mapping registers through the write channel. Valid stays
  // high across the whole burst and drops once at the end.
  task program_registers(logic [FIX_W-1:0] ox, logic [FIX_W-1:0] oy,
                         logic [FIX_W-1:0] cx, logic [FIX_W-1:0] cy,
                         logic [FIX_W-1:0] rx, logic [FIX_W-1:0] ry,
                         logic [FIX_W-1:0] w,  logic [FIX_W-1:0] h);
    logic [FIX_W-1:0] words [8];
    words[REG_ORIGIN_X]   = ox;
    words[REG_ORIGIN_Y]   = oy;
    words[REG_COL_STEP_X] = cx;
    words[REG_COL_STEP_Y] = cy;
    words[REG_ROW_STEP_X] = rx;
    words[REG_ROW_STEP_Y] = ry;
    words[REG_SCREEN_W]   = w;
    words[REG_SCREEN_H]   = h;
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= words[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_register(cfg_idx_e'(i), words[i]);
    end
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  function automatic void queue_pixel(int x, int y, logic [COLOR_W-1:0] color);
    pixel_req_t req;
    req.x     = COORD_W'(x);
    req.y     = COORD_W'(y);
    req.color = color;
    pixel_q.push_back(req);
  endfunction

  // Sends every queued pixel. With idling on, an idle gap of random length
  // sometimes falls between requests; junk sits on the data ports meanwhile.
  task stream_pixels(bit idle_en);
    pixel_req_t req;
    int         gap;
    while (pixel_q.size() != 0) begin
      req = pixel_q.pop_front();
      start         <= 1'b1;
      src_x_i       <= req.x;
      src_y_i       <= req.y;
      pixel_color_i <= req.color;
      do @(posedge clk_i); while (busy);
      requests_taken++;
      if (idle_en && pixel_q.size() != 0 && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 12);
        start         <= 1'b0;
        src_x_i       <= COORD_W'($urandom());
        src_y_i       <= COORD_W'($urandom());
        pixel_color_i <= $urandom();
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b0;
  endtask

  // Registers may only change once every outstanding result has come back.
  task wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int signed_pick(int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // Screen size word: mostly a legal size, sometimes zero, sometimes above the
  // maximum so that it saturates; the unused upper bits carry noise.
  function automatic logic [FIX_W-1:0] random_dim_word();
    logic [FIX_W-1:0] word;
    int               pick;
    word = $urandom();
    pick = $urandom_range(0, 19);
    if (pick == 0)     word[DIM_W-1:0] = '0;
    else if (pick < 4) word[DIM_W-1:0] = DIM_W'($urandom_range(MAX_DIM + 1, 4095));
    else               word[DIM_W-1:0] = DIM_W'($urandom_range(1, MAX_DIM));
    return word;
  endfunction

  // One random register setting followed by a batch of pixels. Mode 0 is a plausible
  // rotate and scale or a general small-step map, mode 1 uses whole-pixel steps with
  // origins on or next to a half so rounding ties come up often, mode 2 is raw noise.
  task random_phase(int mode, int n_items, bit idle_en);
    int               a, b;
    logic [15:0]      frac_x, frac_y;
    logic [15:0]      fracs [3];
    int               lim;
    fracs[0] = 16'h7FFF;
    fracs[1] = 16'h8000;
    fracs[2] = 16'h8001;
    if (mode == 0) begin
      a = signed_pick(3 << 16);
      b = signed_pick(3 << 16);
      if ($urandom_range(0, 1) == 1)
        program_registers(signed_pick(1024 << 16) + (512 << 16),
                          signed_pick(1024 << 16) + (512 << 16),
                          a, b, -b, a, random_dim_word(), random_dim_word());
      else
        program_registers(signed_pick(1024 << 16) + (512 << 16),
                          signed_pick(1024 << 16) + (512 << 16),
                          a, b, signed_pick(3 << 16), signed_pick(3 << 16),
                          random_dim_word(), random_dim_word());
    end else if (mode == 1) begin
      frac_x = fracs[$urandom_range(0, 2)];
      frac_y = fracs[$urandom_range(0, 2)];
      program_registers({16'(signed_pick(600) + 300), frac_x},
                        {16'(signed_pick(600) + 300), frac_y},
                        signed_pick(2) <<< 16, signed_pick(2) <<< 16,
                        signed_pick(2) <<< 16, signed_pick(2) <<< 16,
                        random_dim_word(), random_dim_word());
    end else begin
      program_registers($urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom(), $urandom());
    end
    for (int i = 0; i < n_items; i++) begin
      // Plausible maps use a small source tile half the time so many land on screen.
      lim = (mode != 2 && $urandom_range(0, 1) == 1) ? 300 : 2047;
      queue_pixel($urandom_range(0, lim), $urandom_range(0, lim), $urandom());
    end
    stream_pixels(idle_en);
    wait_idle();
  endtask

  initial begin
    sb = new();
    cycles          = 0;
    requests_taken  = 0;
    settings_loaded = 0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    src_x_i       <= '0;
    src_y_i       <= '0;
    pixel_color_i <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_ORIGIN_X;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: identity map onto a 640 by 480 screen, corners and edges.
    queue_pixel(0, 0, 32'h0000_0000);
    queue_pixel(2047, 2047, 32'hFFFF_FFFF);
    queue_pixel(639, 479, 32'hAAAA_AAAA);
    queue_pixel(640, 479, 32'h5555_5555);
    queue_pixel(639, 480, 32'h0123_4567);
    queue_pixel(1, 1, 32'hFEDC_BA98);
    stream_pixels(1'b0);
    wait_idle();

    // Origin at plus and minus one half: a positive half rounds up, a negative
    // half rounds down off the screen. Full 2048 square screen, top index.
    program_registers(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 32'h0000_0000,
                      32'h0000_0000, 32'h0001_0000, 32'h0000_0800, 32'h0000_0800);
    queue_pixel(0, 0, $urandom());
    queue_pixel(0, 1, $urandom());
    queue_pixel(3, 5, $urandom());
    queue_pixel(2047, 2047, $urandom());
    queue_pixel(2046, 2046, $urandom());
    stream_pixels(1'b0);
    wait_idle();

    // Extreme register values with a zero-width screen: nothing may land, and
    // the large products must not wrap on the way.
    program_registers(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_F000, 32'h0000_0FFF);
    queue_pixel(0, 0, $urandom());
    queue_pixel(2047, 0, $urandom());
    queue_pixel(0, 2047, $urandom());
    queue_pixel(2047, 2047, $urandom());
    stream_pixels(1'b0);
    wait_idle();

    // Oversized screen saturates to the maximum, which shows in the index and in
    // the row bound; a value just above minus one half rounds to zero.
    program_registers(32'h07FF_7FFF, 32'hFFFF_8001, 32'h0000_0000, 32'h0002_0000,
                      32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0FFF);
    queue_pixel(0, 0, $urandom());
    queue_pixel(1023, 9, $urandom());
    queue_pixel(1024, 0, $urandom());
    stream_pixels(1'b0);
    wait_idle();

    // Quarter turn with a negative step, back on the default screen size.
    program_registers(32'h027F_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
                      32'hFFFF_0000, 32'h0000_0000, 32'h0000_0280, 32'h0000_01E0);
    queue_pixel(0, 0, $urandom());
    queue_pixel(479, 639, $urandom());
    queue_pixel(480, 5, $urandom());
    queue_pixel(0, 640, $urandom());
    stream_pixels(1'b0);
    wait_idle();

    // Random settings. The first and last batches run without idle cycles.
    for (int p = 0; p < RANDOM_PHASES; p++)
      random_phase((p % 4 == 3) ? 2 : ((p % 4 == 1) ? 1 : 0), PIXELS_PER_PHASE,
                   p != 0 && p != RANDOM_PHASES - 1);

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Mapped %0d pixel requests under %0d register settings.",
             requests_taken, settings_loaded + 1);
    $display("%0d results checked: %0d on screen, %0d off screen, %0d errors.",
             sb.results_seen, sb.inside_seen, sb.results_seen - sb.inside_seen,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("affine_forward_pixel_mapper_core: match");
    end else begin
      $display("affine_forward_pixel_mapper_core: mismatch");
    end
    $finish;
  end

endmodule
